// ===== src/dtpd_pkg.sv =====
`timescale 1ns / 1ps

package dtpd_pkg;

	typedef enum logic [2:0] {
		CODE_UNKNOWN  = 3'd0,
		CODE_MFM_4489 = 3'd1,
		CODE_GCR      = 3'd2,
		CODE_PROLOGUE = 3'd3,
		CODE_MFM_A1   = 3'd4
	} dtpd_code_t;

	// register indexes on the write port
	localparam logic REG_GCR_SYNC_MIN = 1'b0;
	localparam logic REG_MFM_SYNC_MIN = 1'b1;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	localparam logic [7:0] BYTE_SYNC_HI = 8'h44;
	localparam logic [7:0] BYTE_SYNC_LO = 8'h89;
	localparam logic [7:0] BYTE_FF      = 8'hFF;
	localparam logic [7:0] BYTE_D5      = 8'hD5;
	localparam logic [7:0] BYTE_AA      = 8'hAA;
	localparam logic [7:0] BYTE_96      = 8'h96;
	localparam logic [7:0] BYTE_A1      = 8'hA1;

	localparam logic [17:0] LEN_MIN       = 18'd1000;
	localparam logic [17:0] LEN_SYNC_LO   = 18'd100000;
	localparam logic [17:0] LEN_SYNC_HI   = 18'd120000;
	localparam logic [17:0] LEN_GCR_LO    = 18'd40000;
	localparam logic [17:0] LEN_GCR_HI    = 18'd80000;
	localparam logic [17:0] LEN_PROLOG_LO = 18'd48000;
	localparam logic [17:0] LEN_PROLOG_HI = 18'd56000;
	localparam logic [17:0] LEN_A1_LO     = 18'd50000;
	localparam logic [17:0] LEN_A1_HI     = 18'd100000;

	// what the scanner has seen so far in the track, current byte included
	typedef struct packed {
		logic        sync_seen;
		logic        prologue_seen;
		logic [15:0] ff_count;
		logic [15:0] triple_count;
	} dtpd_obs_t;

endpackage

// ===== src/dtpd_scan.sv =====
`timescale 1ns / 1ps

module dtpd_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        track_byte,
	input  logic              last_byte,
	output dtpd_pkg::dtpd_obs_t obs
);
	import dtpd_pkg::*;

	logic [7:0]  prev_q;
	logic [7:0]  prev_prev_q;
	logic [1:0]  idx_q;
	logic        sync_q;
	logic        prologue_q;
	logic [15:0] ff_q;
	logic [15:0] a1_q;
	logic        pair_ok;
	logic        triple_ok;

	assign pair_ok   = (idx_q != 2'd0);
	assign triple_ok = idx_q[1];

	always_comb begin
		obs.sync_seen     = sync_q;
		obs.prologue_seen = prologue_q;
		obs.ff_count      = ff_q;
		obs.triple_count  = a1_q;
		if (pair_ok) begin
			if (prev_q == BYTE_SYNC_HI && track_byte == BYTE_SYNC_LO) begin
				obs.sync_seen = 1'b1;
			end
			if (prev_q == BYTE_FF && track_byte == BYTE_FF && ff_q != COUNT_MAX) begin
				obs.ff_count = ff_q + 16'd1;
			end
		end
		if (triple_ok) begin
			if (prev_prev_q == BYTE_D5 && prev_q == BYTE_AA && track_byte == BYTE_96) begin
				obs.prologue_seen = 1'b1;
			end
			if (prev_prev_q == BYTE_A1 && prev_q == BYTE_A1 && track_byte == BYTE_A1
					&& a1_q != COUNT_MAX) begin
				obs.triple_count = a1_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			prev_prev_q <= '0;
			idx_q       <= '0;
			sync_q      <= 1'b0;
			prologue_q  <= 1'b0;
			ff_q        <= '0;
			a1_q        <= '0;
		end else if (en) begin
			if (last_byte) begin
				// next byte opens a new track
				prev_q      <= '0;
				prev_prev_q <= '0;
				idx_q       <= '0;
				sync_q      <= 1'b0;
				prologue_q  <= 1'b0;
				ff_q        <= '0;
				a1_q        <= '0;
			end else begin
				prev_q      <= track_byte;
				prev_prev_q <= prev_q;
				if (idx_q != 2'd3) begin
					idx_q <= idx_q + 2'd1;
				end
				sync_q      <= obs.sync_seen;
				prologue_q  <= obs.prologue_seen;
				ff_q        <= obs.ff_count;
				a1_q        <= obs.triple_count;
			end
		end
	end

endmodule

// ===== src/dtpd_classify.sv =====
`timescale 1ns / 1ps

module dtpd_classify (
	input  logic                bit_length_in,
	input  logic [17:0]         bit_length,
	input  dtpd_pkg::dtpd_obs_t obs,
	input  logic [15:0]         gcr_sync_min,
	input  logic [15:0]         mfm_sync_min,
	output dtpd_pkg::dtpd_code_t code
);
	import dtpd_pkg::*;

	logic win_sync;
	logic win_gcr;
	logic win_prolog;
	logic win_a1;

	assign win_sync   = (bit_length >= LEN_SYNC_LO)   && (bit_length <= LEN_SYNC_HI);
	assign win_gcr    = (bit_length >= LEN_GCR_LO)    && (bit_length <= LEN_GCR_HI);
	assign win_prolog = (bit_length >= LEN_PROLOG_LO) && (bit_length <= LEN_PROLOG_HI);
	assign win_a1     = (bit_length >= LEN_A1_LO)     && (bit_length <= LEN_A1_HI);

	// first matching test wins
	always_comb begin
		code = CODE_UNKNOWN;
		if (!bit_length_in || bit_length < LEN_MIN) begin
			code = CODE_UNKNOWN;
		end else if (win_sync && obs.sync_seen) begin
			code = CODE_MFM_4489;
		end else if (win_gcr && obs.ff_count >= gcr_sync_min) begin
			code = CODE_GCR;
		end else if (win_prolog && obs.prologue_seen) begin
			code = CODE_PROLOGUE;
		end else if (win_a1 && obs.triple_count >= mfm_sync_min) begin
			code = CODE_MFM_A1;
		end
	end

endmodule

// ===== src/disk_track_platform_detector.sv =====
`timescale 1ns / 1ps

// Track platform detector.
// Input channel (in_valid/in_ready): one raw track byte per request, with the
// track length in bits and a flag on the final byte of the track. One byte is
// taken every cycle while the receiver keeps up.
// Output channel (out_valid/out_ready): one request per track, issued for the
// final byte, carrying the platform code and the FF FF pair and A1 A1 A1
// triple totals. Bytes that are not last give no output.
// Path: a last byte is loaded into the input register when accepted, then its
// result into the result register once that register is free. Throughput is
// one byte per cycle while the receiver keeps up.
// When the receiver stalls, non-last bytes keep flowing; a last byte waits in
// the input register and in_ready drops until the held result is taken.
// Registers gcr_sync_min (index 0) and mfm_sync_min (index 1) are written by
// wr_en/wr_index/wr_data; the user must write them only while no track is in
// flight, which the block itself does not enforce. Reset clears the pattern
// state, empties both stages and loads the register defaults 10 and 9.
module disk_track_platform_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [15:0] wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  track_byte,
	input  logic [17:0] bit_length,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  platform_code,
	output logic [15:0] ff_pair_total,
	output logic [15:0] a1_triple_total
);
	import dtpd_pkg::*;

	logic [15:0] gcr_min_q;
	logic [15:0] mfm_min_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [17:0] len_s1;
	logic        last_s1;
	logic        adv_s1;

	logic        out_valid_q;
	dtpd_code_t  code_q;
	logic [15:0] ff_total_q;
	logic [15:0] a1_total_q;

	dtpd_obs_t   obs;
	dtpd_code_t  code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcr_min_q <= 16'd10;
			mfm_min_q <= 16'd9;
		end else if (wr_en) begin
			case (wr_index)
				REG_GCR_SYNC_MIN: gcr_min_q <= wr_data;
				REG_MFM_SYNC_MIN: mfm_min_q <= wr_data;
				default: ;
			endcase
		end
	end

	// a last byte moves on only when the result register is free
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= track_byte;
			len_s1  <= bit_length;
			last_s1 <= last_byte;
		end
	end

	dtpd_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv_s1),
		.track_byte (byte_s1),
		.last_byte  (last_s1),
		.obs        (obs)
	);

	dtpd_classify u_classify (
		.bit_length_in (valid_s1),
		.bit_length    (len_s1),
		.obs           (obs),
		.gcr_sync_min  (gcr_min_q),
		.mfm_sync_min  (mfm_min_q),
		.code          (code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			code_q     <= code;
			ff_total_q <= obs.ff_count;
			a1_total_q <= obs.triple_count;
		end
	end

	assign out_valid       = out_valid_q;
	assign platform_code   = code_q;
	assign ff_pair_total   = ff_total_q;
	assign a1_triple_total = a1_total_q;

endmodule

// ===== src/dtpd_checker.sv =====
`timescale 1ns / 1ps

module dtpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  platform_code,
	input logic [15:0] ff_pair_total,
	input logic [15:0] a1_triple_total
);
	import dtpd_pkg::*;

	// input side only backs up behind a stalled result
	a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("in_ready low without a stalled result");

	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (platform_code == CODE_UNKNOWN || platform_code == CODE_MFM_4489
			|| platform_code == CODE_GCR || platform_code == CODE_PROLOGUE
			|| platform_code == CODE_MFM_A1))
		else $error("platform code out of range");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(platform_code)
			&& $stable(ff_pair_total) && $stable(a1_triple_total)))
		else $error("stalled result changed");

endmodule

bind disk_track_platform_detector dtpd_checker u_dtpd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.platform_code   (platform_code),
	.ff_pair_total   (ff_pair_total),
	.a1_triple_total (a1_triple_total)
);

// ===== tb/disk_track_platform_detector_test.sv =====
`timescale 1ns / 1ps

module disk_track_platform_detector_test;
	import dtpd_pkg::*;

	localparam int unsigned HOLD_AT = 40;
	localparam int unsigned HOLD_CYCLES = 300;

	localparam logic [17:0] LENGTH_EDGES [0:18] = '{
		18'd0, 18'd999, 18'd1000, 18'd39999, 18'd40000, 18'd47999, 18'd48000,
		18'd49999, 18'd50000, 18'd56000, 18'd56001, 18'd80000, 18'd80001,
		18'd99999, 18'd100000, 18'd100001, 18'd120000, 18'd120001, 18'h3FFFF
	};

	localparam logic [7:0] PATTERN_BYTES [0:6] = '{
		BYTE_SYNC_HI, BYTE_SYNC_LO, BYTE_FF, BYTE_D5, BYTE_AA, BYTE_96, BYTE_A1
	};

	typedef struct packed {
		logic [2:0]  code;
		logic [15:0] ff_pairs;
		logic [15:0] a1_triples;
	} track_verdict_t;

	class platform_ledger;
		logic [15:0]    gcr_min;
		logic [15:0]    mfm_min;
		logic [7:0]     prior_byte;
		logic [7:0]     older_byte;
		int unsigned    depth;
		bit             sync_hit;
		bit             prologue_hit;
		logic [15:0]    ff_pairs;
		logic [15:0]    a1_triples;
		track_verdict_t verdicts_due[$];
		int unsigned    mismatches;

		function new();
			gcr_min = 16'd10;
			mfm_min = 16'd9;
			mismatches = 0;
			open_track();
		endfunction

		function void open_track();
			prior_byte = 8'h00;
			older_byte = 8'h00;
			depth = 0;
			sync_hit = 1'b0;
			prologue_hit = 1'b0;
			ff_pairs = 16'd0;
			a1_triples = 16'd0;
		endfunction

		function void set_threshold(logic index, logic [15:0] value);
			if (index == REG_GCR_SYNC_MIN) begin
				gcr_min = value;
			end else begin
				mfm_min = value;
			end
		endfunction

		function dtpd_code_t classify_track(logic [17:0] bits);
			if (bits < LEN_MIN)
				return CODE_UNKNOWN;
			if (bits >= LEN_SYNC_LO && bits <= LEN_SYNC_HI && sync_hit)
				return CODE_MFM_4489;
			if (bits >= LEN_GCR_LO && bits <= LEN_GCR_HI && ff_pairs >= gcr_min)
				return CODE_GCR;
			if (bits >= LEN_PROLOG_LO && bits <= LEN_PROLOG_HI && prologue_hit)
				return CODE_PROLOGUE;
			if (bits >= LEN_A1_LO && bits <= LEN_A1_HI && a1_triples >= mfm_min)
				return CODE_MFM_A1;
			return CODE_UNKNOWN;
		endfunction

		function void take_byte(logic [7:0] cur, logic [17:0] bits, logic last);
			track_verdict_t v;
			if (depth >= 1) begin
				if (prior_byte == BYTE_SYNC_HI && cur == BYTE_SYNC_LO)
					sync_hit = 1'b1;
				if (prior_byte == BYTE_FF && cur == BYTE_FF && ff_pairs != COUNT_MAX)
					ff_pairs++;
			end
			if (depth >= 2) begin
				if (older_byte == BYTE_D5 && prior_byte == BYTE_AA && cur == BYTE_96)
					prologue_hit = 1'b1;
				if (older_byte == BYTE_A1 && prior_byte == BYTE_A1 && cur == BYTE_A1 &&
						a1_triples != COUNT_MAX)
					a1_triples++;
			end
			older_byte = prior_byte;
			prior_byte = cur;
			if (depth < 3)
				depth++;
			if (last) begin
				v.code = classify_track(bits);
				v.ff_pairs = ff_pairs;
				v.a1_triples = a1_triples;
				verdicts_due.push_back(v);
				open_track();
			end
		endfunction

		function void match_verdict(logic [2:0] code, logic [15:0] ff, logic [15:0] a1);
			track_verdict_t v;
			if (verdicts_due.size() == 0) begin
				$error("unexpected result: platform_code %0d ff_pair_total %0d a1_triple_total %0d",
					code, ff, a1);
				mismatches++;
				return;
			end
			v = verdicts_due.pop_front();
			if (code !== v.code) begin
				$error("platform_code: expected %0d, got %0d", v.code, code);
				mismatches++;
			end
			if (ff !== v.ff_pairs) begin
				$error("ff_pair_total: expected %0d, got %0d", v.ff_pairs, ff);
				mismatches++;
			end
			if (a1 !== v.a1_triples) begin
				$error("a1_triple_total: expected %0d, got %0d", v.a1_triples, a1);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return verdicts_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic        wr_index = 1'b0;
	logic [15:0] wr_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  track_byte = 8'd0;
	logic [17:0] bit_length = 18'd0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  platform_code;
	logic [15:0] ff_pair_total;
	logic [15:0] a1_triple_total;

	platform_ledger ledger = new();
	logic [7:0]     track_body[$];
	bit             fast_input = 1'b0;
	bit             fast_output = 1'b0;
	int unsigned    results_taken = 0;

	disk_track_platform_detector u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.track_byte      (track_byte),
		.bit_length      (bit_length),
		.last_byte       (last_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.platform_code   (platform_code),
		.ff_pair_total   (ff_pair_total),
		.a1_triple_total (a1_triple_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [17:0] pick_length();
		case ($urandom_range(0, 3))
			0, 1: return LENGTH_EDGES[$urandom_range(0, 18)];
			2: return 18'($urandom_range(40000, 120000));
			default: return 18'($urandom_range(0, 262143));
		endcase
	endfunction

	// mostly sync patterns, some broken ones, some noise
	function automatic void build_body();
		int unsigned chunks;
		int unsigned run;
		track_body.delete();
		if ($urandom_range(0, 19) == 0) begin
			track_body.push_back(8'($urandom_range(0, 255)));
			return;
		end
		chunks = $urandom_range(1, 8);
		repeat (chunks) begin
			case ($urandom_range(0, 9))
				2: begin
					track_body.push_back(BYTE_SYNC_HI);
					track_body.push_back(BYTE_SYNC_LO);
				end
				3: begin
					track_body.push_back(BYTE_SYNC_HI);
					track_body.push_back(8'($urandom_range(0, 255)));
				end
				4: begin
					run = $urandom_range(1, 14);
					repeat (run) track_body.push_back(BYTE_FF);
				end
				5: begin
					track_body.push_back(BYTE_D5);
					track_body.push_back(BYTE_AA);
					track_body.push_back(BYTE_96);
				end
				6: begin
					track_body.push_back(BYTE_D5);
					track_body.push_back($urandom_range(0, 1) ? BYTE_AA : 8'($urandom_range(0, 255)));
					track_body.push_back(8'($urandom_range(0, 255)));
				end
				7: begin
					run = $urandom_range(1, 8);
					repeat (run) track_body.push_back(BYTE_A1);
				end
				8: track_body.push_back(PATTERN_BYTES[$urandom_range(0, 6)]);
				default: track_body.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	task automatic send_byte(logic [7:0] cur, logic [17:0] bits, logic last);
		int unsigned gap;
		gap = fast_input ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		track_byte <= cur;
		bit_length <= bits;
		last_byte <= last;
		// hold the request until in_ready
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ledger.take_byte(cur, bits, last);
	endtask

	// length is only sampled on the last byte, so other bytes sometimes carry junk
	task automatic send_track(logic [17:0] bits);
		logic [17:0] stray;
		bit          last;
		foreach (track_body[i]) begin
			last = (i == track_body.size() - 1);
			stray = ($urandom_range(0, 7) == 0) ? 18'($urandom_range(0, 262143)) : bits;
			send_byte(track_body[i], last ? bits : stray, last);
		end
	endtask

	task automatic run_tracks(int unsigned byte_goal);
		int unsigned sent;
		sent = 0;
		while (sent < byte_goal) begin
			fast_input = ($urandom_range(0, 3) == 0);
			build_body();
			sent += track_body.size();
			send_track(pick_length());
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_thresholds(logic [15:0] gcr, logic [15:0] mfm);
		wr_en <= 1'b1;
		wr_index <= REG_GCR_SYNC_MIN;
		wr_data <= gcr;
		@(posedge clk);
		wr_index <= REG_MFM_SYNC_MIN;
		wr_data <= mfm;
		@(posedge clk);
		wr_en <= 1'b0;
		ledger.set_threshold(REG_GCR_SYNC_MIN, gcr);
		ledger.set_threshold(REG_MFM_SYNC_MIN, mfm);
	endtask

	initial begin : receiver
		int unsigned stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				ledger.match_verdict(platform_code, ff_pair_total, a1_triple_total);
				results_taken++;
				if ($urandom_range(0, 4) == 0)
					fast_output = !fast_output;
				stall_left = fast_output ? 0 : $urandom_range(0, 14);
				// one long back-pressure window so the input side has to stall
				if (results_taken == HOLD_AT)
					stall_left = HOLD_CYCLES;
			end else if (stall_left != 0) begin
				stall_left--;
			end
			out_ready <= (stall_left == 0);
		end
	end

	initial begin : stimulus
		int unsigned k;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		track_body = '{8'h00};
		send_track(18'd0);
		track_body = '{BYTE_SYNC_HI, BYTE_SYNC_LO};
		send_track(LEN_SYNC_LO);
		// sync pair split over a track boundary must not count
		track_body = '{BYTE_SYNC_HI};
		send_track(18'h3FFFF);
		track_body = '{BYTE_SYNC_LO};
		send_track(18'd110000);
		track_body = '{BYTE_D5, BYTE_AA, BYTE_96};
		send_track(LEN_PROLOG_HI);
		track_body = '{BYTE_A1, BYTE_A1, BYTE_A1, BYTE_A1};
		send_track(18'd999);
		track_body = '{BYTE_FF};
		send_track(LEN_MIN);
		track_body = '{BYTE_FF, BYTE_FF};
		send_track(LEN_MIN);
		track_body = '{BYTE_A1, BYTE_A1};
		send_track(LEN_A1_LO);
		track_body = '{BYTE_A1};
		send_track(LEN_A1_LO);
		track_body = '{BYTE_FF, BYTE_FF, BYTE_SYNC_HI, BYTE_SYNC_LO};
		send_track(LEN_SYNC_HI);
		settle();

		write_thresholds(16'd0, 16'd0);
		track_body = '{8'h5A};
		send_track(LEN_GCR_LO);
		track_body = '{8'h5A};
		send_track(LEN_GCR_HI + 18'd1);
		// gcr window wins over the prologue
		track_body = '{BYTE_D5, BYTE_AA, BYTE_96};
		send_track(LEN_PROLOG_LO);
		track_body = '{8'h5A};
		send_track(LEN_SYNC_HI + 18'd1);

		for (k = 0; k < 8; k++) begin
			settle();
			case (k)
				0: write_thresholds(16'd10, 16'd9);
				1: write_thresholds(16'hFFFF, 16'hFFFF);
				2: write_thresholds(16'd0, 16'hFFFF);
				3: write_thresholds(16'hFFFF, 16'd0);
				4: write_thresholds(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
				default: write_thresholds(16'($urandom_range(1, 12)), 16'($urandom_range(1, 5)));
			endcase
			run_tracks(150);
		end

		settle();
		repeat (8) @(posedge clk);
		if (ledger.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/dtpd_pkg.sv
src/dtpd_scan.sv
src/dtpd_classify.sv
src/disk_track_platform_detector.sv
src/dtpd_checker.sv
tb/disk_track_platform_detector_test.sv
